/* rtl/rmq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;
   localparam int ELEM_WIDTH = 16;
   localparam int FRAC_BITS  = 14;

   typedef enum logic [1:0] {
      PIVOT_W = 2'd0,
      PIVOT_X = 2'd1,
      PIVOT_Y = 2'd2,
      PIVOT_Z = 2'd3
   } pivot_type;
endpackage
`default_nettype wire

/* rtl/rotation_matrix_to_quaternion_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Rotation matrix to unit quaternion.
// req_ channel: one 3x3 matrix per word, nine signed fixed-point elements.
// rsp_ channel: one quaternion (qw,qx,qy,qz) plus bad_input per word.
// Front stage: trace, pivot choice, radicand and the three numerators.
// Square root: pipelined, one root bit per stage, RAD_W/2 stages (17 at the
// default widths). Divide: pipelined, one quotient bit per stage, NUM_W
// stages (32), three lanes. Then combinational saturation into the output register.
// Register stages in all: RAD_W/2 + NUM_W + 2 (51 at the default widths).
// Throughput: one word per cycle. The whole pipeline advances when the
// output register is empty or being taken; a stalled receiver freezes every
// stage, so nothing is lost or repeated, and req_ready drops with it.
// A non-positive radicand yields all-zero components and bad_input.
// Reset (synchronous) clears all valid bits; data registers are not reset.
module rotation_matrix_to_quaternion_core #(
   parameter int ELEM_WIDTH = rmq_pkg::ELEM_WIDTH,
   parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [ELEM_WIDTH-1:0] req_m00,
   input  wire logic signed [ELEM_WIDTH-1:0] req_m01,
   input  wire logic signed [ELEM_WIDTH-1:0] req_m02,
   input  wire logic signed [ELEM_WIDTH-1:0] req_m10,
   input  wire logic signed [ELEM_WIDTH-1:0] req_m11,
   input  wire logic signed [ELEM_WIDTH-1:0] req_m12,
   input  wire logic signed [ELEM_WIDTH-1:0] req_m20,
   input  wire logic signed [ELEM_WIDTH-1:0] req_m21,
   input  wire logic signed [ELEM_WIDTH-1:0] req_m22,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [ELEM_WIDTH-1:0]      rsp_qw,
   output logic signed [ELEM_WIDTH-1:0]      rsp_qx,
   output logic signed [ELEM_WIDTH-1:0]      rsp_qy,
   output logic signed [ELEM_WIDTH-1:0]      rsp_qz,
   output logic                              rsp_bad_input
);
   localparam int EW    = ELEM_WIDTH;
   localparam int SW    = EW + 3;                 // sums of three elements
   localparam int NW    = EW + 1;                 // pair sums/differences
   localparam int RAD_W = 2 * ((SW + FRAC_BITS + 1) / 2);
   localparam int RTW   = RAD_W / 2;
   localparam int DEN_W = RTW + 1;
   localparam int NUM_W = NW + FRAC_BITS + 1;
   localparam int SIDE_W = 2 + 1 + 3 * NW;

   logic adv;
   logic out_vld_ff;
   assign adv       = !out_vld_ff || rsp_ready;
   assign req_ready = adv;

   // front stage
   logic signed [EW-1:0] m [3][3];
   assign m[0][0] = req_m00; assign m[0][1] = req_m01; assign m[0][2] = req_m02;
   assign m[1][0] = req_m10; assign m[1][1] = req_m11; assign m[1][2] = req_m12;
   assign m[2][0] = req_m20; assign m[2][1] = req_m21; assign m[2][2] = req_m22;

   logic signed [SW-1:0] trace_in, rad_in;
   logic signed [NW-1:0] n0_in, n1_in, n2_in;
   rmq_pkg::pivot_type   piv_in;
   logic signed [SW-1:0] one_s;
   assign one_s = SW'(1) <<< FRAC_BITS;

   always_comb begin
      logic signed [SW-1:0] d0, d1, d2;
      d0 = SW'(m[0][0]); d1 = SW'(m[1][1]); d2 = SW'(m[2][2]);
      trace_in = d0 + d1 + d2;
      if (trace_in > 0) begin
         piv_in = rmq_pkg::PIVOT_W;
         rad_in = trace_in + one_s;
         n0_in  = NW'(m[2][1]) - NW'(m[1][2]);
         n1_in  = NW'(m[0][2]) - NW'(m[2][0]);
         n2_in  = NW'(m[1][0]) - NW'(m[0][1]);
      end else if (m[2][2] > m[1][1] && m[2][2] > m[0][0]) begin
         piv_in = rmq_pkg::PIVOT_Z;              // i=2, j=0, k=1
         rad_in = d2 - d0 - d1 + one_s;
         n0_in  = NW'(m[1][0]) - NW'(m[0][1]);   // w
         n1_in  = NW'(m[0][2]) + NW'(m[2][0]);   // x (j)
         n2_in  = NW'(m[1][2]) + NW'(m[2][1]);   // y (k)
      end else if (m[1][1] > m[0][0]) begin
         piv_in = rmq_pkg::PIVOT_Y;              // i=1, j=2, k=0
         rad_in = d1 - d2 - d0 + one_s;
         n0_in  = NW'(m[0][2]) - NW'(m[2][0]);   // w
         n1_in  = NW'(m[2][1]) + NW'(m[1][2]);   // z (j)
         n2_in  = NW'(m[0][1]) + NW'(m[1][0]);   // x (k)
      end else begin
         piv_in = rmq_pkg::PIVOT_X;              // i=0, j=1, k=2
         rad_in = d0 - d1 - d2 + one_s;
         n0_in  = NW'(m[2][1]) - NW'(m[1][2]);   // w
         n1_in  = NW'(m[1][0]) + NW'(m[0][1]);   // y (j)
         n2_in  = NW'(m[2][0]) + NW'(m[0][2]);   // z (k)
      end
   end

   logic                 f_vld_ff;
   logic signed [SW-1:0] f_rad_ff;
   logic [SIDE_W-1:0]    f_side_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (adv) begin
         f_vld_ff <= req_valid;
      end
      if (adv) begin
         f_rad_ff  <= rad_in;
         f_side_ff <= {piv_in, rad_in <= 0, n0_in, n1_in, n2_in};
      end
   end

   logic [RAD_W-1:0] sq_rad;
   assign sq_rad = (f_rad_ff > 0) ? (RAD_W'(f_rad_ff) << FRAC_BITS) : '0;

   logic              s_vld;
   logic [RTW-1:0]    s_root;
   logic [SIDE_W-1:0] s_side;
   rmq_sqrt #(.RAD_WIDTH(RAD_W), .SIDE_WIDTH(SIDE_W)) u_sqrt (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(f_vld_ff), .in_rad(sq_rad), .in_side(f_side_ff),
      .out_valid(s_vld), .out_root(s_root), .out_side(s_side)
   );

   // numerator = |n|<<FRAC + s, denominator = 2s (forced nonzero if s==0)
   logic signed [NW-1:0] sn [3];
   assign sn[0] = s_side[3*NW-1 -: NW];
   assign sn[1] = s_side[2*NW-1 -: NW];
   assign sn[2] = s_side[NW-1:0];
   logic [DEN_W-1:0] den;
   assign den = (s_root == '0) ? DEN_W'(1) : {s_root, 1'b0};

   logic [NUM_W-1:0] quo [3];
   for (genvar g = 0; g < 3; g++) begin : g_div
      logic [NW-1:0]    mag;
      logic [NUM_W-1:0] num;
      assign mag = sn[g][NW-1] ? NW'(-sn[g]) : NW'(sn[g]);
      assign num = (NUM_W'(mag) << FRAC_BITS) + NUM_W'(s_root);
      rmq_div #(.NUM_WIDTH(NUM_W), .DEN_WIDTH(DEN_W)) u_div (
         .clock(clock), .adv(adv), .in_num(num), .in_den(den), .out_quo(quo[g])
      );
   end

   // delay line for control/root alongside the dividers
   logic [NUM_W:0]    d_vld_ff;
   logic [SIDE_W-1:0] d_side_ff [NUM_W+1];
   logic [RTW-1:0]    d_root_ff [NUM_W+1];
   always_comb begin
      d_vld_ff[0]  = s_vld;
      d_side_ff[0] = s_side;
      d_root_ff[0] = s_root;
   end
   for (genvar g = 0; g < NUM_W; g++) begin : g_dly
      always_ff @(posedge clock) begin
         if (reset) begin
            d_vld_ff[g+1] <= 1'b0;
         end else if (adv) begin
            d_vld_ff[g+1] <= d_vld_ff[g];
         end
         if (adv) begin
            d_side_ff[g+1] <= d_side_ff[g];
            d_root_ff[g+1] <= d_root_ff[g];
         end
      end
   end

   // final: signs, placement, saturation
   logic [SIDE_W-1:0] e_side;
   rmq_pkg::pivot_type e_piv;
   logic e_nonpos;
   assign e_side   = d_side_ff[NUM_W];
   assign e_piv    = rmq_pkg::pivot_type'(e_side[SIDE_W-1 -: 2]);
   assign e_nonpos = e_side[3*NW];

   localparam int CW = NUM_W + 2;
   logic signed [CW-1:0] c [3];
   logic signed [CW-1:0] pv;
   logic signed [CW-1:0] cw_in, cx_in, cy_in, cz_in;
   logic [EW-1:0] ow_in, ox_in, oy_in, oz_in;
   logic          bad_in;

   function automatic logic [EW:0] sat_f(input logic signed [CW-1:0] v);
      logic signed [CW-1:0] hi, lo;
      hi = CW'((64'sd1 <<< (EW - 1)) - 64'sd1);
      lo = -hi - CW'(1);
      if (v > hi)      sat_f = {1'b1, EW'(hi)};
      else if (v < lo) sat_f = {1'b1, EW'(lo)};
      else             sat_f = {1'b0, EW'(v)};
   endfunction

   always_comb begin
      logic [EW:0] rw, rx, ry, rz;
      for (int g = 0; g < 3; g++) begin
         c[g] = e_side[(3-g)*NW-1] ? -CW'(quo[g]) : CW'(quo[g]);
      end
      pv = CW'((CW'(d_root_ff[NUM_W]) + CW'(1)) >>> 1);
      case (e_piv)
         rmq_pkg::PIVOT_W: begin
            cw_in = pv; cx_in = c[0]; cy_in = c[1]; cz_in = c[2];
         end
         rmq_pkg::PIVOT_X: begin
            cw_in = c[0]; cx_in = pv; cy_in = c[1]; cz_in = c[2];
         end
         rmq_pkg::PIVOT_Y: begin
            cw_in = c[0]; cy_in = pv; cz_in = c[1]; cx_in = c[2];
         end
         rmq_pkg::PIVOT_Z: begin
            cw_in = c[0]; cz_in = pv; cx_in = c[1]; cy_in = c[2];
         end
         default: begin
            cw_in = '0; cx_in = '0; cy_in = '0; cz_in = '0;
         end
      endcase
      rw = sat_f(cw_in); rx = sat_f(cx_in); ry = sat_f(cy_in); rz = sat_f(cz_in);
      if (e_nonpos) begin
         ow_in = '0; ox_in = '0; oy_in = '0; oz_in = '0;
         bad_in = 1'b1;
      end else begin
         ow_in = rw[EW-1:0]; ox_in = rx[EW-1:0];
         oy_in = ry[EW-1:0]; oz_in = rz[EW-1:0];
         bad_in = rw[EW] | rx[EW] | ry[EW] | rz[EW];
      end
   end

   logic [EW-1:0] qw_ff, qx_ff, qy_ff, qz_ff;
   logic          bad_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= d_vld_ff[NUM_W];
      end
      if (adv) begin
         qw_ff  <= ow_in;
         qx_ff  <= ox_in;
         qy_ff  <= oy_in;
         qz_ff  <= oz_in;
         bad_ff <= bad_in;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_qw        = qw_ff;
   assign rsp_qx        = qx_ff;
   assign rsp_qy        = qy_ff;
   assign rsp_qz        = qz_ff;
   assign rsp_bad_input = bad_ff;

`ifndef SYNTHESIS
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_qw) && $stable(rsp_bad_input))
      else $error("result word changed while stalled");
   a_ready_adv: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("pipeline stalled with empty output");
   // an unflagged word always carries a positive pivot component
   a_pivot_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bad_input |->
         rsp_qw > 0 || rsp_qx > 0 || rsp_qy > 0 || rsp_qz > 0)
      else $error("bad result word");
`endif
endmodule
`default_nettype wire

/* rtl/rmq_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
// Pipelined integer square root, one result bit per stage.
// A sideband word rides along with each operand.
module rmq_sqrt #(
   parameter int RAD_WIDTH  = 36,
   parameter int SIDE_WIDTH = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire logic                  in_valid,
   input  wire logic [RAD_WIDTH-1:0]  in_rad,
   input  wire logic [SIDE_WIDTH-1:0] in_side,
   output logic                       out_valid,
   output logic [RAD_WIDTH/2-1:0]     out_root,
   output logic [SIDE_WIDTH-1:0]      out_side
);
   localparam int NSTG = RAD_WIDTH / 2;
   localparam int RW   = NSTG;

   logic [NSTG:0]                  vld_ff;
   logic [RAD_WIDTH-1:0]           rem_ff  [NSTG+1];
   logic [RAD_WIDTH-1:0]           rad_ff  [NSTG+1];
   logic [RW-1:0]                  root_ff [NSTG+1];
   logic [SIDE_WIDTH-1:0]          side_ff [NSTG+1];

   always_comb begin
      vld_ff[0]  = in_valid;
      rem_ff[0]  = '0;
      rad_ff[0]  = in_rad;
      root_ff[0] = '0;
      side_ff[0] = in_side;
   end

   for (genvar g = 0; g < NSTG; g++) begin : g_stg
      logic [RAD_WIDTH-1:0] rem_in;
      logic [RAD_WIDTH-1:0] trial_in;
      logic [RW-1:0]        root_in;
      always_comb begin
         rem_in   = {rem_ff[g][RAD_WIDTH-3:0], rad_ff[g][RAD_WIDTH-1 -: 2]};
         trial_in = {{(RAD_WIDTH-RW-2){1'b0}}, root_ff[g], 2'b01};
         root_in  = {root_ff[g][RW-2:0], 1'b0};
         if (rem_in >= trial_in) begin
            rem_in  = rem_in - trial_in;
            root_in = {root_ff[g][RW-2:0], 1'b1};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[g+1] <= vld_ff[g];
         end
         if (adv) begin
            rem_ff[g+1]  <= rem_in;
            rad_ff[g+1]  <= {rad_ff[g][RAD_WIDTH-3:0], 2'b00};
            root_ff[g+1] <= root_in;
            side_ff[g+1] <= side_ff[g];
         end
      end
   end

   assign out_valid = vld_ff[NSTG];
   assign out_root  = root_ff[NSTG];
   assign out_side  = side_ff[NSTG];
endmodule
`default_nettype wire

/* rtl/rmq_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage: q = num / den.
module rmq_div #(
   parameter int NUM_WIDTH = 32,
   parameter int DEN_WIDTH = 20
) (
   input  wire logic                 clock,
   input  wire logic                 adv,
   input  wire logic [NUM_WIDTH-1:0] in_num,
   input  wire logic [DEN_WIDTH-1:0] in_den,
   output logic [NUM_WIDTH-1:0]      out_quo
);
   localparam int RMW = DEN_WIDTH + 1;

   logic [NUM_WIDTH-1:0] num_ff [NUM_WIDTH+1];
   logic [RMW-1:0]       rem_ff [NUM_WIDTH+1];
   logic [DEN_WIDTH-1:0] den_ff [NUM_WIDTH+1];

   always_comb begin
      num_ff[0] = in_num;
      rem_ff[0] = '0;
      den_ff[0] = in_den;
   end

   for (genvar g = 0; g < NUM_WIDTH; g++) begin : g_stg
      logic [RMW:0]         sh_in;
      logic [RMW-1:0]       rem_in;
      logic                 bit_in;
      always_comb begin
         sh_in  = {rem_ff[g], num_ff[g][NUM_WIDTH-1]};
         bit_in = sh_in >= {2'b00, den_ff[g]};
         rem_in = bit_in ? RMW'(sh_in - {2'b00, den_ff[g]}) : RMW'(sh_in);
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            num_ff[g+1] <= {num_ff[g][NUM_WIDTH-2:0], bit_in};
            rem_ff[g+1] <= rem_in;
            den_ff[g+1] <= den_ff[g];
         end
      end
   end

   assign out_quo = num_ff[NUM_WIDTH];
endmodule
`default_nettype wire

/* bench/rotation_matrix_to_quaternion_core_tb.sv */
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_core_tb;

   localparam int W = rmq_pkg::ELEM_WIDTH;
   localparam int FB = rmq_pkg::FRAC_BITS;
   localparam int PIPE_LAT = 90;
   localparam int STALL_LIMIT = 4000;
   localparam int N_RANDOM = 1130;
   localparam int LONG_HOLD = 300;
   localparam logic signed [W-1:0] ONE_Q = 16'sd16384;

   typedef logic signed [W-1:0] elem_t;
   typedef struct packed {
      elem_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
   } matrix_t;
   typedef struct packed {
      elem_t w, x, y, z;
      logic  bad;
   } quat_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   matrix_t drv_mat = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   elem_t rsp_qw, rsp_qx, rsp_qy, rsp_qz;
   logic rsp_bad_input;

   matrix_t pending_mats[$];
   quat_t   expected_quats[$];
   int      mismatches = 0;
   int      accepted_in = 0;
   int      accepted_out = 0;
   int      bad_seen = 0;
   int      idle_cycles = 0;
   bit      stim_done = 1'b0;
   bit      hold_sender = 1'b0;
   bit      hold_receiver = 1'b0;

   rotation_matrix_to_quaternion_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_m00(drv_mat.m00), .req_m01(drv_mat.m01), .req_m02(drv_mat.m02),
      .req_m10(drv_mat.m10), .req_m11(drv_mat.m11), .req_m12(drv_mat.m12),
      .req_m20(drv_mat.m20), .req_m21(drv_mat.m21), .req_m22(drv_mat.m22),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_qw(rsp_qw), .rsp_qx(rsp_qx), .rsp_qy(rsp_qy), .rsp_qz(rsp_qz),
      .rsp_bad_input(rsp_bad_input)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // n / (2s), rounded half away from zero
   function automatic longint half_div(longint n, longint unsigned s);
      longint unsigned mag, q;
      mag = (n < 0) ? longint'(-n) : n;
      q = ((mag << FB) + s) / (2 * s);
      return (n < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic elem_t clamp(longint v, inout bit sat);
      longint hi, lo;
      hi = (64'sd1 <<< (W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin v = hi; sat = 1'b1; end
      if (v < lo) begin v = lo; sat = 1'b1; end
      return elem_t'(v);
   endfunction

   function automatic quat_t matrix_to_quat(matrix_t mt);
      longint m[3][3];
      longint comp[4];
      longint tr, rad;
      longint unsigned s;
      int i, j, k;
      bit sat;
      quat_t q;
      m[0][0] = mt.m00; m[0][1] = mt.m01; m[0][2] = mt.m02;
      m[1][0] = mt.m10; m[1][1] = mt.m11; m[1][2] = mt.m12;
      m[2][0] = mt.m20; m[2][1] = mt.m21; m[2][2] = mt.m22;
      sat = 1'b0;
      tr = m[0][0] + m[1][1] + m[2][2];
      if (tr > 0) begin
         rad = tr + (64'sd1 <<< FB);
         s = int_sqrt(longint'(rad) << FB);
         comp[0] = (s + 1) >> 1;
         comp[1] = half_div(m[2][1] - m[1][2], s);
         comp[2] = half_div(m[0][2] - m[2][0], s);
         comp[3] = half_div(m[1][0] - m[0][1], s);
      end else begin
         i = 0;
         if (m[1][1] > m[0][0]) i = 1;
         if (m[2][2] > m[i][i]) i = 2;
         j = (i + 1) % 3;
         k = (j + 1) % 3;
         rad = m[i][i] - m[j][j] - m[k][k] + (64'sd1 <<< FB);
         if (rad <= 0) begin
            q = '0;
            q.bad = 1'b1;
            return q;
         end
         s = int_sqrt(longint'(rad) << FB);
         comp[1 + i] = (s + 1) >> 1;
         comp[0] = half_div(m[k][j] - m[j][k], s);
         comp[1 + j] = half_div(m[j][i] + m[i][j], s);
         comp[1 + k] = half_div(m[k][i] + m[i][k], s);
      end
      q.w = clamp(comp[0], sat);
      q.x = clamp(comp[1], sat);
      q.y = clamp(comp[2], sat);
      q.z = clamp(comp[3], sat);
      q.bad = sat;
      return q;
   endfunction

   function automatic elem_t rand_elem();
      case ($urandom_range(0, 5))
         0: return elem_t'($urandom);
         1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         default: return elem_t'(int'($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   // rotation by angle about one axis, with small noise on every entry
   function automatic matrix_t rand_rotation();
      real ang, c, s;
      elem_t e[9];
      int ax;
      ang = ($urandom_range(0, 62831) / 10000.0);
      c = $cos(ang) * 16384.0;
      s = $sin(ang) * 16384.0;
      ax = $urandom_range(0, 2);
      foreach (e[n]) e[n] = '0;
      e[ax * 4] = ONE_Q;
      case (ax)
         0: begin e[4] = elem_t'($rtoi(c)); e[5] = elem_t'(-$rtoi(s));
            e[7] = elem_t'($rtoi(s)); e[8] = elem_t'($rtoi(c)); end
         1: begin e[0] = elem_t'($rtoi(c)); e[2] = elem_t'($rtoi(s));
            e[6] = elem_t'(-$rtoi(s)); e[8] = elem_t'($rtoi(c)); end
         default: begin e[0] = elem_t'($rtoi(c)); e[1] = elem_t'(-$rtoi(s));
            e[3] = elem_t'($rtoi(s)); e[4] = elem_t'($rtoi(c)); end
      endcase
      foreach (e[n]) e[n] = e[n] + elem_t'(int'($urandom_range(0, 8)) - 4);
      return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
   endfunction

   function automatic matrix_t rand_matrix();
      matrix_t mt;
      mt = rand_rotation();
      case ($urandom_range(0, 9))
         0, 1: mt = {rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                     rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                     rand_elem()};
         2: mt.m01 = rand_elem();
         3: begin mt.m00 = -mt.m00; mt.m11 = -mt.m11; mt.m22 = -mt.m22; end
         default: ;
      endcase
      return mt;
   endfunction

   initial begin
      elem_t ext[4];
      ext[0] = 16'sh8000; ext[1] = 16'sh7fff; ext[2] = '0; ext[3] = -16'sd1;
      pending_mats.push_back({ONE_Q, 16'sd0, 16'sd0, 16'sd0, ONE_Q, 16'sd0,
                              16'sd0, 16'sd0, ONE_Q});
      // half turns: trace negative, pivot x, y, z
      pending_mats.push_back({ONE_Q, 16'sd0, 16'sd0, 16'sd0, -ONE_Q, 16'sd0,
                              16'sd0, 16'sd0, -ONE_Q});
      pending_mats.push_back({-ONE_Q, 16'sd0, 16'sd0, 16'sd0, ONE_Q, 16'sd0,
                              16'sd0, 16'sd0, -ONE_Q});
      pending_mats.push_back({-ONE_Q, 16'sd0, 16'sd0, 16'sd0, -ONE_Q, 16'sd0,
                              16'sd0, 16'sd0, ONE_Q});
      // diagonal ties keep the lower index
      pending_mats.push_back('0);
      pending_mats.push_back({-ONE_Q, 16'sd0, 16'sd0, 16'sd0, -ONE_Q, 16'sd0,
                              16'sd0, 16'sd0, -ONE_Q});
      // diagonal all at the negative extreme: trace negative, pivot x
      pending_mats.push_back({16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sh8000,
                              16'sd0, 16'sd0, 16'sd0, 16'sh8000});
      // saturating components, off-diagonal extremes
      pending_mats.push_back({16'sd0, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sd0,
                              16'sh8000, 16'sh8000, 16'sh7fff, 16'sd0});
      pending_mats.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                              16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                              16'sh7fff});
      pending_mats.push_back({16'sd1, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sd0,
                              16'sh7fff, 16'sh7fff, 16'sh8000, 16'sd0});
      for (int n = 0; n < 12; n++)
         pending_mats.push_back({ext[n % 4], ext[(n + 1) % 4], ext[(n + 2) % 4],
                                 ext[(n + 3) % 4], ext[n / 4 % 4], ext[n % 3],
                                 ext[(n + 2) % 3], ext[3 - n % 4], ext[n % 2]});
      for (int n = 0; n < N_RANDOM; n++)
         pending_mats.push_back(rand_matrix());
      stim_done = 1'b1;
   end

   // accept at the rising edge; remembered for the driver and receiver
   logic req_ready_q = 1'b0;
   logic rsp_taken_q = 1'b0;
   always @(posedge clock) begin
      req_ready_q <= !reset && req_valid && req_ready;
      rsp_taken_q <= !reset && rsp_valid && rsp_ready;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         expected_quats.push_back(matrix_to_quat(drv_mat));
         accepted_in <= accepted_in + 1;
      end
   end

   // driver: a new word may follow an accepted one with no gap
   int send_gap = 0;
   int sent_count = 0;
   always @(negedge clock) begin
      int g;
      g = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
      if (!reset && (!req_valid || req_ready_q)) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (!hold_sender && pending_mats.size() > 0) begin
            drv_mat <= pending_mats.pop_front();
            req_valid <= 1'b1;
            sent_count <= sent_count + 1;
            send_gap <= g;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, with one long hold-off counted here
   int recv_gap = 0;
   bit long_hold_done = 1'b0;
   always @(negedge clock) begin
      int g;
      g = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
      if (!reset) begin
         if (hold_receiver && !long_hold_done) begin
            long_hold_done <= 1'b1;
            recv_gap <= LONG_HOLD - 1;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else if (rsp_taken_q && g > 0) begin
            recv_gap <= g - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      quat_t exp_q, got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_qw, rsp_qx, rsp_qy, rsp_qz, rsp_bad_input};
         accepted_out <= accepted_out + 1;
         if (got.bad) bad_seen <= bad_seen + 1;
         if (expected_quats.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
               $display("unexpected word: %p", got);
         end else begin
            exp_q = expected_quats.pop_front();
            if (got !== exp_q) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch: expected %p got %p", exp_q, got);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // long receiver hold-off while the sender keeps offering
      wait (sent_count >= 200);
      @(negedge clock);
      hold_receiver = 1'b1;
      // sender pauses until the pipeline drains
      wait (sent_count >= 600);
      @(negedge clock);
      hold_sender = 1'b1;
      wait (expected_quats.size() == 0 && !req_valid);
      hold_sender = 1'b0;
      wait (stim_done && pending_mats.size() == 0 && !req_valid);
      wait (expected_quats.size() == 0);
      repeat (PIPE_LAT) @(posedge clock);
      $display("covered %0d matrices, %0d quaternions, %0d flagged bad",
               accepted_in, accepted_out, bad_seen);
      if (mismatches == 0 && expected_quats.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb: failure");
      end
      $finish;
   end
endmodule
